### hw/rtl/cps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the closest-point-on-segments block
// no dependencies; used by cps_ctrl, cps_datapath and the top level under hw/rtl

package cps_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;
    localparam int FIELD_W             = 32;
    localparam int FRAC_W              = 32;
    localparam int DIST_W              = 64;
    localparam int PADDR_W             = 4;
    localparam int PDATA_W             = 64;

    localparam logic [DIST_W-1:0] THRESH_RESET = 64'd42949673;

    // register select, taken from paddr[3] (8-byte register spacing)
    localparam logic REG_DEGENERATE_THRESHOLD = 1'b0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_SQ_DX,
        OP_SQ_DY,
        OP_DOT_X,
        OP_DOT_Y,
        OP_DOT_SUM,
        OP_CLASSIFY,
        OP_OFS_X,
        OP_OFS_Y,
        OP_OFS_END,
        OP_DIST_DIFF,
        OP_SQ_PX,
        OP_SQ_PY,
        OP_DIST_SUM,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic               first_item;
        logic [FIELD_W-1:0] query_x;
        logic [FIELD_W-1:0] query_y;
        logic [FIELD_W-1:0] query_z;
        logic [FIELD_W-1:0] start_x;
        logic [FIELD_W-1:0] start_y;
        logic [FIELD_W-1:0] end_x;
        logic [FIELD_W-1:0] end_y;
    } item_t;

endpackage

### hw/rtl/cps_div.sv
`timescale 1ns / 1ps
// restoring divider: one quotient bit per cycle, fraction of num/den with num < den
// depends on nothing but its parameters

module cps_div #(
    parameter int DEN_W = 65,
    parameter int Q_W   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot,
    output logic             done
);

    localparam int CNT_W = $clog2(Q_W + 1);
    localparam int REM_W = DEN_W + 1;

    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den};
    assign fits    = shifted >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(Q_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quot_reg <= {quot_reg[Q_W-2:0], fits};
        end
    end

    assign quot = quot_reg;
    assign done = (cnt_reg == '0);

endmodule

### hw/rtl/cps_datapath.sv
`timescale 1ns / 1ps
// datapath: held query, best result, shared multiplier, projection and distance
// depends on cps_pkg and cps_div

module cps_datapath #(
    parameter int COORD_WIDTH = cps_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cps_pkg::cmd_t                 cmd,
    output cps_pkg::status_t              st,
    input  cps_pkg::item_t                item,
    input  logic [cps_pkg::DIST_W-1:0]    threshold,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cps_pkg::FIELD_W-1:0]   nearest_x,
    output logic [cps_pkg::FIELD_W-1:0]   nearest_y,
    output logic [cps_pkg::FIELD_W-1:0]   nearest_z,
    output logic                          any_found
);

    localparam int CW     = COORD_WIDTH;
    localparam int FRAC_W = cps_pkg::FRAC_W;
    localparam int DIST_W = cps_pkg::DIST_W;
    localparam int FW     = cps_pkg::FIELD_W;
    localparam int PROD_W = FRAC_W + CW;
    localparam int SQ_W   = 2 * CW;
    localparam int DEN_W  = 2 * CW + 1;
    localparam int NUM_W  = 2 * CW + 2;
    localparam int CMP_W  = (DEN_W > DIST_W) ? DEN_W : DIST_W;

    // signed difference a - b as {negative, magnitude}
    function automatic logic [CW:0] sub_sm(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] d;
        logic [CW:0] m;
        d = {a[CW-1], a} - {b[CW-1], b};
        m = d[CW] ? (~d + (CW+1)'(1)) : d;
        return {d[CW], m[CW-1:0]};
    endfunction

    function automatic logic [NUM_W-1:0] signed_term(input logic neg, input logic [SQ_W-1:0] p);
        logic [NUM_W-1:0] e;
        e = NUM_W'(p);
        return neg ? (~e + NUM_W'(1)) : e;
    endfunction

    // state kept across items
    logic [CW-1:0]     held_x_reg, held_y_reg, held_z_reg;
    logic [CW-1:0]     best_x_reg, best_y_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              best_valid_reg;
    logic              out_valid_reg;

    // per-segment working registers
    logic [CW-1:0]     sx_reg, sy_reg, ex_reg, ey_reg;
    logic [CW-1:0]     mdx_reg, mdy_reg, mpx_reg, mpy_reg;
    logic              sdx_reg, sdy_reg, spx_reg, spy_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [CW-1:0]     ix_reg, iy_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [FW-1:0]     out_x_reg, out_y_reg, out_z_reg;
    logic              out_found_reg;

    logic [CW:0]       dx_sm, dy_sm, px_sm, py_sm, qx_sm, qy_sm;
    logic [FRAC_W-1:0] mul_a;
    logic [CW-1:0]     mul_b;
    logic [SQ_W-1:0]   sq;
    logic [CW-1:0]     ofs;
    logic [DIST_W:0]   dist_sum;
    logic              degen, num_pos, num_ge, need_div, pick_end;
    logic [FRAC_W-1:0] quot;
    logic              div_done;

    assign dx_sm = sub_sm(ex_reg, sx_reg);
    assign dy_sm = sub_sm(ey_reg, sy_reg);
    assign px_sm = sub_sm(held_x_reg, sx_reg);
    assign py_sm = sub_sm(held_y_reg, sy_reg);
    assign qx_sm = sub_sm(ix_reg, held_x_reg);
    assign qy_sm = sub_sm(iy_reg, held_y_reg);

    assign sq       = prod_reg[SQ_W-1:0];
    assign ofs      = prod_reg[FRAC_W +: CW];
    assign dist_sum = (DIST_W+1)'(dist_reg) + (DIST_W+1)'(sq);

    // projection cases: short segment or behind start, past end, or inside
    assign degen    = CMP_W'(den_reg) <= CMP_W'(threshold);
    assign num_pos  = !num_reg[NUM_W-1] && (num_reg != '0);
    assign num_ge   = num_reg >= NUM_W'(den_reg);
    assign need_div = !degen && num_pos && !num_ge;
    assign pick_end = !degen && num_pos && num_ge;

    always_comb
    begin
        unique case (cmd.op)
            cps_pkg::OP_SQ_DX:
            begin
                mul_a = FRAC_W'(mdx_reg);
                mul_b = mdx_reg;
            end
            cps_pkg::OP_SQ_DY:
            begin
                mul_a = FRAC_W'(mdy_reg);
                mul_b = mdy_reg;
            end
            cps_pkg::OP_DOT_X:
            begin
                mul_a = FRAC_W'(mpx_reg);
                mul_b = mdx_reg;
            end
            cps_pkg::OP_DOT_Y:
            begin
                mul_a = FRAC_W'(mpy_reg);
                mul_b = mdy_reg;
            end
            cps_pkg::OP_OFS_X:
            begin
                mul_a = quot;
                mul_b = mdx_reg;
            end
            cps_pkg::OP_OFS_Y:
            begin
                mul_a = quot;
                mul_b = mdy_reg;
            end
            cps_pkg::OP_SQ_PX:
            begin
                mul_a = FRAC_W'(mpx_reg);
                mul_b = mpx_reg;
            end
            cps_pkg::OP_SQ_PY:
            begin
                mul_a = FRAC_W'(mpy_reg);
                mul_b = mpy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    cps_div #(
        .DEN_W (DEN_W),
        .Q_W   (FRAC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg[DEN_W-1:0]),
        .den   (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_z_reg     <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_dist_reg  <= '1;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == cps_pkg::OP_LOAD && item.first_item)
            begin
                held_x_reg     <= item.query_x[CW-1:0];
                held_y_reg     <= item.query_y[CW-1:0];
                held_z_reg     <= item.query_z[CW-1:0];
                best_x_reg     <= item.query_x[CW-1:0];
                best_y_reg     <= item.query_y[CW-1:0];
                best_dist_reg  <= '1;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.op == cps_pkg::OP_UPDATE && (!best_valid_reg || dist_reg < best_dist_reg))
            begin
                best_x_reg     <= ix_reg;
                best_y_reg     <= iy_reg;
                best_dist_reg  <= dist_reg;
                best_valid_reg <= 1'b1;
            end

            if (cmd.op == cps_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);

        unique case (cmd.op)
            cps_pkg::OP_LOAD:
            begin
                sx_reg <= item.start_x[CW-1:0];
                sy_reg <= item.start_y[CW-1:0];
                ex_reg <= item.end_x[CW-1:0];
                ey_reg <= item.end_y[CW-1:0];
            end
            cps_pkg::OP_DIFF:
            begin
                {sdx_reg, mdx_reg} <= dx_sm;
                {sdy_reg, mdy_reg} <= dy_sm;
                {spx_reg, mpx_reg} <= px_sm;
                {spy_reg, mpy_reg} <= py_sm;
            end
            cps_pkg::OP_SQ_DY:
            begin
                den_reg <= DEN_W'(sq);
            end
            cps_pkg::OP_DOT_X:
            begin
                den_reg <= den_reg + DEN_W'(sq);
            end
            cps_pkg::OP_DOT_Y:
            begin
                num_reg <= signed_term(spx_reg ^ sdx_reg, sq);
            end
            cps_pkg::OP_DOT_SUM:
            begin
                num_reg <= num_reg + signed_term(spy_reg ^ sdy_reg, sq);
            end
            cps_pkg::OP_CLASSIFY:
            begin
                ix_reg <= pick_end ? ex_reg : sx_reg;
                iy_reg <= pick_end ? ey_reg : sy_reg;
            end
            cps_pkg::OP_OFS_Y:
            begin
                ix_reg <= sdx_reg ? (sx_reg - ofs) : (sx_reg + ofs);
            end
            cps_pkg::OP_OFS_END:
            begin
                iy_reg <= sdy_reg ? (sy_reg - ofs) : (sy_reg + ofs);
            end
            cps_pkg::OP_DIST_DIFF:
            begin
                mpx_reg <= qx_sm[CW-1:0];
                mpy_reg <= qy_sm[CW-1:0];
            end
            cps_pkg::OP_SQ_PY:
            begin
                dist_reg <= DIST_W'(sq);
            end
            cps_pkg::OP_DIST_SUM:
            begin
                // saturate at 64 bits
                dist_reg <= dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
            end
            cps_pkg::OP_EMIT:
            begin
                out_x_reg     <= FW'($signed(best_x_reg));
                out_y_reg     <= FW'($signed(best_y_reg));
                out_z_reg     <= FW'($signed(held_z_reg));
                out_found_reg <= best_valid_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign st.need_div = need_div;
    assign st.div_done = div_done;
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign nearest_x = out_x_reg;
    assign nearest_y = out_y_reg;
    assign nearest_z = out_z_reg;
    assign any_found = out_found_reg;

endmodule

### hw/rtl/cps_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences one request through the datapath and emits results
// depends on cps_pkg

module cps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              last_item,
    input  logic              segment_present,
    input  cps_pkg::status_t  st,
    output cps_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_SQ_DX,
        S_SQ_DY,
        S_DOT_X,
        S_DOT_Y,
        S_DOT_SUM,
        S_CLASSIFY,
        S_DIV,
        S_OFS_X,
        S_OFS_Y,
        S_OFS_END,
        S_DIST_DIFF,
        S_SQ_PX,
        S_SQ_PY,
        S_DIST_SUM,
        S_UPDATE,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= last_item;
                        if (segment_present)
                        begin
                            state_reg <= S_DIFF;
                        end
                        else if (last_item)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_DIFF:      state_reg <= S_SQ_DX;
                S_SQ_DX:     state_reg <= S_SQ_DY;
                S_SQ_DY:     state_reg <= S_DOT_X;
                S_DOT_X:     state_reg <= S_DOT_Y;
                S_DOT_Y:     state_reg <= S_DOT_SUM;
                S_DOT_SUM:   state_reg <= S_CLASSIFY;
                S_CLASSIFY:  state_reg <= st.need_div ? S_DIV : S_DIST_DIFF;
                S_DIV:
                begin
                    if (st.div_done)
                    begin
                        state_reg <= S_OFS_X;
                    end
                end
                S_OFS_X:     state_reg <= S_OFS_Y;
                S_OFS_Y:     state_reg <= S_OFS_END;
                S_OFS_END:   state_reg <= S_DIST_DIFF;
                S_DIST_DIFF: state_reg <= S_SQ_PX;
                S_SQ_PX:     state_reg <= S_SQ_PY;
                S_SQ_PY:     state_reg <= S_DIST_SUM;
                S_DIST_SUM:  state_reg <= S_UPDATE;
                S_UPDATE:    state_reg <= last_reg ? S_EMIT : S_IDLE;
                S_EMIT:
                begin
                    // wait for the output register to drain
                    if (st.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.div_start = (state_reg == S_CLASSIFY) && st.need_div;
        unique case (state_reg)
            S_IDLE:      cmd.op = in_valid ? cps_pkg::OP_LOAD : cps_pkg::OP_NONE;
            S_DIFF:      cmd.op = cps_pkg::OP_DIFF;
            S_SQ_DX:     cmd.op = cps_pkg::OP_SQ_DX;
            S_SQ_DY:     cmd.op = cps_pkg::OP_SQ_DY;
            S_DOT_X:     cmd.op = cps_pkg::OP_DOT_X;
            S_DOT_Y:     cmd.op = cps_pkg::OP_DOT_Y;
            S_DOT_SUM:   cmd.op = cps_pkg::OP_DOT_SUM;
            S_CLASSIFY:  cmd.op = cps_pkg::OP_CLASSIFY;
            S_DIV:       cmd.op = cps_pkg::OP_NONE;
            S_OFS_X:     cmd.op = cps_pkg::OP_OFS_X;
            S_OFS_Y:     cmd.op = cps_pkg::OP_OFS_Y;
            S_OFS_END:   cmd.op = cps_pkg::OP_OFS_END;
            S_DIST_DIFF: cmd.op = cps_pkg::OP_DIST_DIFF;
            S_SQ_PX:     cmd.op = cps_pkg::OP_SQ_PX;
            S_SQ_PY:     cmd.op = cps_pkg::OP_SQ_PY;
            S_DIST_SUM:  cmd.op = cps_pkg::OP_DIST_SUM;
            S_UPDATE:    cmd.op = cps_pkg::OP_UPDATE;
            S_EMIT:      cmd.op = st.out_free ? cps_pkg::OP_EMIT : cps_pkg::OP_NONE;
            default:     cmd.op = cps_pkg::OP_NONE;
        endcase
    end

endmodule

### hw/rtl/closest_point_on_segments_top.sv
`timescale 1ns / 1ps
// top level: request and result channels, threshold register, controller and datapath
// depends on cps_pkg, cps_ctrl, cps_datapath (and cps_div below it)
//
//  channel  | handshake                       | carries
//  ---------+---------------------------------+--------------------------------------
//  in       | in_valid / in_ready             | flags, query point, one segment
//  out      | out_valid / out_ready           | nearest point, z, any_found
//  cfg      | psel, penable, pwrite / pready  | degenerate_threshold at paddr 0
//
// a request with a segment runs the 32-step restoring divider only when the projection
// falls inside the segment, not when it clamps or the segment is short; all products
// use the one shared 32x32 multiplier. a request without segment stays idle unless it
// is last. a last request passes the emit state to load the output register, and waits
// there while a previous result is still not taken. no clearing pass after reset.

module closest_point_on_segments_top #(
    parameter int COORD_WIDTH = cps_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          first_item,
    input  logic                          last_item,
    input  logic                          segment_present,
    input  logic [cps_pkg::FIELD_W-1:0]   query_x,
    input  logic [cps_pkg::FIELD_W-1:0]   query_y,
    input  logic [cps_pkg::FIELD_W-1:0]   query_z,
    input  logic [cps_pkg::FIELD_W-1:0]   start_x,
    input  logic [cps_pkg::FIELD_W-1:0]   start_y,
    input  logic [cps_pkg::FIELD_W-1:0]   end_x,
    input  logic [cps_pkg::FIELD_W-1:0]   end_y,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cps_pkg::FIELD_W-1:0]   nearest_x,
    output logic [cps_pkg::FIELD_W-1:0]   nearest_y,
    output logic [cps_pkg::FIELD_W-1:0]   nearest_z,
    output logic                          any_found,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cps_pkg::PADDR_W-1:0]   paddr,
    input  logic [cps_pkg::PDATA_W-1:0]   pwdata,
    output logic [cps_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [cps_pkg::DIST_W-1:0] threshold_reg;
    logic                       sel_thresh;
    cps_pkg::cmd_t              cmd;
    cps_pkg::status_t           st;
    cps_pkg::item_t             item;

    assign sel_thresh = (paddr[3] == cps_pkg::REG_DEGENERATE_THRESHOLD);
    assign pready     = 1'b1;
    assign prdata     = sel_thresh ? cps_pkg::PDATA_W'(threshold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= cps_pkg::THRESH_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_thresh)
        begin
            threshold_reg <= cps_pkg::DIST_W'(pwdata);
        end
    end

    assign item.first_item = first_item;
    assign item.query_x    = query_x;
    assign item.query_y    = query_y;
    assign item.query_z    = query_z;
    assign item.start_x    = start_x;
    assign item.start_y    = start_y;
    assign item.end_x      = end_x;
    assign item.end_y      = end_y;

    cps_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .last_item       (last_item),
        .segment_present (segment_present),
        .st              (st),
        .cmd             (cmd)
    );

    cps_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .item      (item),
        .threshold (threshold_reg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .nearest_x (nearest_x),
        .nearest_y (nearest_y),
        .nearest_z (nearest_z),
        .any_found (any_found)
    );

    // divider must be idle whenever a new request can come in
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> st.div_done)
        else $error("divider busy while accepting requests");

    // result load only when the output register is free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cps_pkg::OP_EMIT) |-> st.out_free)
        else $error("result overwritten before it was taken");

    // a segment request keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && segment_present) |=> !in_ready)
        else $error("segment request did not start processing");

    // after an empty non-last request the input is ready again on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !segment_present && !last_item) |=> in_ready)
        else $error("empty request stalled the input");

endmodule
